>>> src/wsrc_pkg.sv
`timescale 1ns / 1ps

package wsrc_pkg;

	typedef enum logic [1:0] {
		ModeTick      = 2'd0,
		ModeCommand   = 2'd1,
		ModeSoftStop  = 2'd2,
		ModeHardStop  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		RegStopValue = 2'd0,
		RegFwdLimit  = 2'd1,
		RegBackLimit = 2'd2,
		RegHoldoff   = 2'd3
	} reg_idx_t;

	localparam logic [11:0] StopValueReset = 12'd512;
	localparam logic [11:0] FwdLimitReset  = 12'd640;
	localparam logic [11:0] BackLimitReset = 12'd384;
	localparam logic [3:0]  HoldoffReset   = 4'd3;

	// output buffer depth and its pointer/count widths
	localparam int unsigned OutDepth = 3;
	localparam int unsigned PtrW     = $clog2(OutDepth);
	localparam int unsigned CntW     = $clog2(OutDepth + 1);

	typedef struct packed {
		logic [11:0] stop_value;
		logic [11:0] fwd_limit;
		logic [11:0] back_limit;
		logic [3:0]  holdoff;
	} cfg_t;

	typedef struct packed {
		logic tick;
		logic cmd;   // command accepted and not refused
		logic stop;  // soft or hard stop: clear target
		logic hard;  // hard stop: drive back to stop value
	} lane_ctrl_t;

	typedef struct packed {
		logic               taken;
		logic signed [15:0] target_right;
		logic signed [15:0] target_left;
		logic [11:0]        drive_right;
		logic [11:0]        drive_left;
	} out_item_t;

endpackage

>>> src/wsrc_lane.sv
`timescale 1ns / 1ps

module wsrc_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  wsrc_pkg::lane_ctrl_t ctrl,
	input  wsrc_pkg::cfg_t      cfg,
	input  logic signed [7:0]   ratio,
	input  logic signed [7:0]   speed,
	input  logic signed [15:0]  measured,
	output logic [11:0]         drive,
	output logic signed [15:0]  target
);
	import wsrc_pkg::*;

	logic [11:0]        drive_q;
	logic [3:0]         hold_q;
	logic signed [15:0] target_q;
	logic               pend_s1;
	logic signed [15:0] num_s1;

	logic signed [15:0] prod;
	logic [15:0]        mag;
	logic [10:0]        mag_div8;
	logic [22:0]        recip_prod;
	logic [8:0]         quot;
	logic signed [15:0] div_target;
	logic signed [15:0] eff_target;

	assign prod = 16'(ratio) * 16'(speed);

	// |num|/40 = (|num|>>3)/5, the /5 by reciprocal 3277/2^14 (exact below 2^14)
	assign mag        = num_s1[15] ? 16'(-num_s1) : num_s1;
	assign mag_div8   = mag[13:3];
	assign recip_prod = 23'(mag_div8) * 23'd3277;
	assign quot       = recip_prod[22:14];
	assign div_target = num_s1[15] ? -$signed(16'(quot)) : $signed(16'(quot));

	// a command taken last cycle is still in num_s1
	assign eff_target = pend_s1 ? div_target : target_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1  <= 1'b0;
			target_q <= '0;
		end else begin
			pend_s1 <= ctrl.cmd;
			if (ctrl.stop) begin
				target_q <= '0;
			end else if (pend_s1) begin
				target_q <= div_target;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.cmd) begin
			num_s1 <= prod + 16'sd20;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q <= StopValueReset;
			hold_q  <= '0;
		end else if (ctrl.hard) begin
			drive_q <= cfg.stop_value;
		end else if (ctrl.tick) begin
			if (hold_q != 4'd0) begin
				hold_q <= hold_q - 4'd1;
			end else if (eff_target > measured) begin
				if (drive_q < cfg.fwd_limit) begin
					drive_q <= drive_q + 12'd1;
				end
				hold_q <= cfg.holdoff;
			end else if (eff_target < measured) begin
				if (drive_q > cfg.back_limit) begin
					drive_q <= drive_q - 12'd1;
				end
				hold_q <= cfg.holdoff;
			end
		end
	end

	assign drive  = drive_q;
	assign target = eff_target;

endmodule

>>> src/wsrc_out_fifo.sv
`timescale 1ns / 1ps

module wsrc_out_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  wsrc_pkg::out_item_t           push_item,
	input  logic                          pop,
	output logic                          not_empty,
	output wsrc_pkg::out_item_t           head_item,
	output logic [wsrc_pkg::CntW-1:0]     count
);
	import wsrc_pkg::*;

	out_item_t         mem_q [OutDepth];
	logic [PtrW-1:0]   wr_q;
	logic [PtrW-1:0]   rd_q;
	logic [CntW-1:0]   count_q;
	logic              do_pop;

	function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
		ptr_next = (p == PtrW'(OutDepth - 1)) ? '0 : p + PtrW'(1);
	endfunction

	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ptr_next(wr_q);
			end
			if (do_pop) begin
				rd_q <= ptr_next(rd_q);
			end
			count_q <= count_q + CntW'(push) - CntW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	assign not_empty = (count_q != '0);
	assign head_item = mem_q[rd_q];
	assign count     = count_q;

endmodule

>>> src/wheel_speed_ramp_controller_unit.sv
`timescale 1ns / 1ps
// Path: the result of an item passes the divide stage, then the output buffer write,
// before it is offered on the m side.
// Throughput: one item per cycle while the output buffer has room; each wheel lane updates its
// state in the accept cycle, and a three-entry output buffer holds results that wait to be taken;
// s_tready drops when it has no room. Reset: arst_n clears targets, hold-offs and the buffer,
// puts both drives at 512 and loads the register reset values; no clearing pass.
module wheel_speed_ramp_controller_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] steer_value, [15:8] speed_value, [31:16] measured_left,
	// [47:32] measured_right, [48] obstacle_seen, [49] ignore_obstacle,
	// [50] override_obstacle, [51] halted, [55:52] zero
	input  logic [55:0] s_tdata,
	// [1:0] mode
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [11:0] drive_left, [23:12] drive_right, [39:24] target_left,
	// [55:40] target_right, [56] command_taken, [63:57] zero
	output logic [63:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import wsrc_pkg::*;

	cfg_t               cfg_q;
	reg_idx_t           reg_idx;
	logic               cfg_wr;

	mode_t              mode;
	logic signed [7:0]  steer;
	logic signed [7:0]  speed;
	logic signed [15:0] meas_l;
	logic signed [15:0] meas_r;
	logic               obstacle;
	logic               ignore_obs;
	logic               override_obs;
	logic               halted;

	logic               s_acc;
	logic               blocked;
	logic               take;
	logic signed [8:0]  ratio_l_w;
	logic signed [8:0]  ratio_r_w;
	lane_ctrl_t         ctrl;

	logic [11:0]        drive_l;
	logic [11:0]        drive_r;
	logic signed [15:0] target_l;
	logic signed [15:0] target_r;

	logic               valid_s1;
	logic               taken_s1;
	out_item_t          push_item;
	out_item_t          head_item;
	logic [CntW-1:0]    buf_count;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_value <= StopValueReset;
			cfg_q.fwd_limit  <= FwdLimitReset;
			cfg_q.back_limit <= BackLimitReset;
			cfg_q.holdoff    <= HoldoffReset;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				RegStopValue: cfg_q.stop_value <= pwdata[11:0];
				RegFwdLimit:  cfg_q.fwd_limit  <= pwdata[11:0];
				RegBackLimit: cfg_q.back_limit <= pwdata[11:0];
				RegHoldoff:   cfg_q.holdoff    <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			RegStopValue: prdata = {20'd0, cfg_q.stop_value};
			RegFwdLimit:  prdata = {20'd0, cfg_q.fwd_limit};
			RegBackLimit: prdata = {20'd0, cfg_q.back_limit};
			RegHoldoff:   prdata = {28'd0, cfg_q.holdoff};
			default:      prdata = '0;
		endcase
	end

	// input item fields
	assign mode         = mode_t'(s_tuser);
	assign steer        = $signed(s_tdata[7:0]);
	assign speed        = $signed(s_tdata[15:8]);
	assign meas_l       = $signed(s_tdata[31:16]);
	assign meas_r       = $signed(s_tdata[47:32]);
	assign obstacle     = s_tdata[48];
	assign ignore_obs   = s_tdata[49];
	assign override_obs = s_tdata[50];
	assign halted       = s_tdata[51];

	// room for the item in flight plus this one
	assign s_tready = (CntW'(buf_count) + CntW'(valid_s1)) < CntW'(OutDepth);
	assign s_acc    = s_tvalid && s_tready;

	assign blocked = obstacle && (drive_l > cfg_q.stop_value) &&
		(drive_r > cfg_q.stop_value) && !ignore_obs && !override_obs;
	assign take    = s_acc && (mode == ModeCommand) && !blocked && !halted;

	// inner wheel ratio is 40 - |steer|
	assign ratio_l_w = steer[7] ? (9'sd40 + 9'(steer)) : 9'sd40;
	assign ratio_r_w = steer[7] ? 9'sd40 : (9'sd40 - 9'(steer));

	always_comb begin
		ctrl.tick = s_acc && (mode == ModeTick);
		ctrl.cmd  = take;
		ctrl.stop = s_acc && ((mode == ModeSoftStop) || (mode == ModeHardStop));
		ctrl.hard = s_acc && (mode == ModeHardStop);
	end

	wsrc_lane u_lane_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.cfg      (cfg_q),
		.ratio    (ratio_l_w[7:0]),
		.speed    (speed),
		.measured (meas_l),
		.drive    (drive_l),
		.target   (target_l)
	);

	wsrc_lane u_lane_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.cfg      (cfg_q),
		.ratio    (ratio_r_w[7:0]),
		.speed    (speed),
		.measured (meas_r),
		.drive    (drive_r),
		.target   (target_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			taken_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_acc;
			taken_s1 <= take;
		end
	end

	// lane state in the cycle after accept is the state after that item
	always_comb begin
		push_item.taken        = taken_s1;
		push_item.target_right = target_r;
		push_item.target_left  = target_l;
		push_item.drive_right  = drive_r;
		push_item.drive_left   = drive_l;
	end

	wsrc_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_item (push_item),
		.pop       (m_tready),
		.not_empty (m_tvalid),
		.head_item (head_item),
		.count     (buf_count)
	);

	assign m_tdata = {7'd0, head_item.taken, head_item.target_right, head_item.target_left,
		head_item.drive_right, head_item.drive_left};

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && (buf_count == CntW'(OutDepth)) && !m_tready))
		else $error("result pushed into full output buffer");

	a_taken_valid: assert property (@(posedge clk) disable iff (!arst_n)
		taken_s1 |-> valid_s1)
		else $error("command flag without item in flight");

	a_hard_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && (mode == ModeHardStop)) |=>
		((drive_l == $past(cfg_q.stop_value)) && (drive_r == $past(cfg_q.stop_value)) &&
		(target_l == 16'sd0) && (target_r == 16'sd0)))
		else $error("hard stop did not park both wheels");

	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && (mode == ModeCommand) && halted) |=> !taken_s1)
		else $error("command taken while halted");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import wsrc_pkg::*;

	localparam int RandomItems = 1800;
	localparam int DrainLimit  = 2000;
	localparam int LongHold    = 80;

	// flag bits for make_cmd: {halted, override, ignore, obstacle}
	localparam logic [3:0] FlagObst     = 4'b0001;
	localparam logic [3:0] FlagIgnore   = 4'b0010;
	localparam logic [3:0] FlagOverride = 4'b0100;
	localparam logic [3:0] FlagHalt     = 4'b1000;

	typedef struct packed {
		mode_t              mode;
		logic               halted;
		logic               ovr_obst;
		logic               ign_obst;
		logic               obstacle;
		logic signed [15:0] meas_r;
		logic signed [15:0] meas_l;
		logic signed [7:0]  speed;
		logic signed [7:0]  steer;
	} wheel_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// [7:0] steer_value, [15:8] speed_value, [31:16] measured_left,
	// [47:32] measured_right, [48] obstacle_seen, [49] ignore_obstacle,
	// [50] override_obstacle, [51] halted, [55:52] zero
	logic [55:0] s_tdata = '0;
	// [1:0] mode
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [11:0] drive_left, [23:12] drive_right, [39:24] target_left,
	// [55:40] target_right, [56] command_taken, [63:57] zero
	logic [63:0] m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// wheel model: configuration and state
	logic [11:0]        stop_val, fwd_lim, back_lim;
	logic [3:0]         holdoff_ticks;
	logic signed [15:0] tgt_l, tgt_r;
	logic [11:0]        drv_l, drv_r;
	logic [3:0]         hold_l, hold_r;
	out_item_t          pending_status[$];

	int error_count = 0;
	int items_sent = 0;
	int tx_gap_max = 9;
	int rx_stall_max = 9;
	logic long_hold_req = 1'b0;

	wheel_speed_ramp_controller_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic void flag_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endfunction

	function automatic void report_field(input string name, input int want, input int got);
		flag_error($sformatf("%s expected %0d, got %0d", name, want, got));
	endfunction

	function automatic void reset_wheel_model();
		stop_val      = StopValueReset;
		fwd_lim       = FwdLimitReset;
		back_lim      = BackLimitReset;
		holdoff_ticks = HoldoffReset;
		tgt_l  = '0;
		tgt_r  = '0;
		drv_l  = StopValueReset;
		drv_r  = StopValueReset;
		hold_l = '0;
		hold_r = '0;
	endfunction

	function automatic int scale40(input int ratio, input int speed);
		return (ratio * speed + 20) / 40;
	endfunction

	function automatic void ramp_wheel(inout logic [11:0] drv, inout logic [3:0] hold,
			input int tgt, input int meas);
		if (hold != 0) begin
			hold = hold - 4'd1;
		end else if (tgt > meas) begin
			if (drv < fwd_lim)
				drv = drv + 12'd1;
			hold = holdoff_ticks;
		end else if (tgt < meas) begin
			if (drv > back_lim)
				drv = drv - 12'd1;
			hold = holdoff_ticks;
		end
	endfunction

	// advances the wheel model by one item and queues the status it should produce
	function automatic void apply_wheel_item(input wheel_cmd_t it);
		out_item_t status;
		int steer, speed, rl, rr;
		logic blocked;
		steer = it.steer;
		speed = it.speed;
		status.taken = 1'b0;
		case (it.mode)
			ModeTick: begin
				ramp_wheel(drv_l, hold_l, tgt_l, it.meas_l);
				ramp_wheel(drv_r, hold_r, tgt_r, it.meas_r);
			end
			ModeCommand: begin
				blocked = it.obstacle && drv_l > stop_val && drv_r > stop_val &&
					!it.ign_obst && !it.ovr_obst;
				if (!blocked && !it.halted) begin
					if (steer >= 0) begin
						rl = 40;
						rr = 40 - steer;
					end else begin
						rl = 40 + steer;
						rr = 40;
					end
					tgt_l = 16'(scale40(rl, speed));
					tgt_r = 16'(scale40(rr, speed));
					status.taken = 1'b1;
				end
			end
			ModeSoftStop: begin
				tgt_l = '0;
				tgt_r = '0;
			end
			default: begin
				tgt_l = '0;
				tgt_r = '0;
				drv_l = stop_val;
				drv_r = stop_val;
			end
		endcase
		status.drive_left   = drv_l;
		status.drive_right  = drv_r;
		status.target_left  = tgt_l;
		status.target_right = tgt_r;
		pending_status.push_back(status);
	endfunction

	function automatic wheel_cmd_t make_cmd(input mode_t mode, input int steer, input int speed,
			input int ml, input int mr, input logic [3:0] flags);
		wheel_cmd_t it;
		it.mode     = mode;
		it.steer    = 8'(steer);
		it.speed    = 8'(speed);
		it.meas_l   = 16'(ml);
		it.meas_r   = 16'(mr);
		it.obstacle = flags[0];
		it.ign_obst = flags[1];
		it.ovr_obst = flags[2];
		it.halted   = flags[3];
		return it;
	endfunction

	// measured speeds mostly sit near the current targets, offset by drift, so the
	// ramps keep stepping in one direction and reach the limits
	function automatic wheel_cmd_t random_item(input mode_t mode, input int drift);
		wheel_cmd_t it;
		int r, jl, jr;
		it.mode   = mode;
		it.steer  = 8'($urandom);
		it.speed  = 8'($urandom);
		it.meas_l = 16'($urandom);
		it.meas_r = 16'($urandom);
		r  = $urandom_range(0, 9);
		jl = int'($urandom_range(0, 4)) - 2;
		jr = int'($urandom_range(0, 4)) - 2;
		if (r < 7) begin
			it.meas_l = 16'(int'(tgt_l) + drift + jl);
			it.meas_r = 16'(int'(tgt_r) + drift + jr);
		end else if (r == 7) begin
			it.meas_l = tgt_l;
			it.meas_r = tgt_r;
		end
		it.obstacle = ($urandom_range(0, 2) == 0);
		it.ign_obst = ($urandom_range(0, 3) == 0);
		it.ovr_obst = ($urandom_range(0, 3) == 0);
		it.halted   = ($urandom_range(0, 9) == 0);
		return it;
	endfunction

	// called and returns at a falling edge; tvalid stays high for back-to-back items
	task automatic send_item(input wheel_cmd_t it);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  = {4'b0, it.halted, it.ovr_obst, it.ign_obst, it.obstacle,
			it.meas_r, it.meas_l, it.speed, it.steer};
		s_tuser  = it.mode;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		apply_wheel_item(it);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		int n;
		s_tvalid = 1'b0;
		n = 0;
		while (pending_status.size() != 0 && n < DrainLimit) begin
			@(negedge clk);
			n++;
		end
		if (pending_status.size() != 0) begin
			flag_error($sformatf("%0d results never arrived", pending_status.size()));
			pending_status.delete();
		end
		repeat (4) @(negedge clk);
	endtask

	// write, then read back in a second transfer
	task automatic write_reg(input reg_idx_t idx, input logic [11:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = 32'(value);
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (prdata !== 32'(value))
			flag_error($sformatf("register %s read %0d, wrote %0d", idx.name(), prdata, value));
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		case (idx)
			RegStopValue: stop_val = value;
			RegFwdLimit:  fwd_lim = value;
			RegBackLimit: back_lim = value;
			default:      holdoff_ticks = value[3:0];
		endcase
	endtask

	task automatic set_config(input logic [11:0] stop, input logic [11:0] fwd,
			input logic [11:0] back, input logic [3:0] hold);
		wait_drained();
		write_reg(RegStopValue, stop);
		write_reg(RegFwdLimit, fwd);
		write_reg(RegBackLimit, back);
		write_reg(RegHoldoff, 12'(hold));
	endtask

	// every result is checked against the oldest pending status
	always @(posedge clk) begin : status_check
		out_item_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[56:0];
			if (pending_status.size() == 0) begin
				flag_error("result with no item pending");
			end else begin
				want = pending_status.pop_front();
				if (got.drive_left !== want.drive_left)
					report_field("drive_left", want.drive_left, got.drive_left);
				if (got.drive_right !== want.drive_right)
					report_field("drive_right", want.drive_right, got.drive_right);
				if (got.target_left !== want.target_left)
					report_field("target_left", want.target_left, got.target_left);
				if (got.target_right !== want.target_right)
					report_field("target_right", want.target_right, got.target_right);
				if (got.taken !== want.taken)
					report_field("command_taken", want.taken, got.taken);
			end
		end
	end

	initial begin : result_sink
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				m_tready = 1'b0;
				repeat (LongHold) @(negedge clk);
				long_hold_req = 1'b0;
			end
			stall = $urandom_range(0, rx_stall_max);
			if (stall != 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic test_commands_and_ramp();
		send_item(make_cmd(ModeHardStop, 0, 0, 0, 0, 4'b0000));
		send_item(make_cmd(ModeCommand, 0, 127, 0, 0, 4'b0000));
		send_item(make_cmd(ModeCommand, 127, -128, 0, 0, 4'b0000));
		send_item(make_cmd(ModeCommand, -128, 127, 0, 0, 4'b0000));
		send_item(make_cmd(ModeCommand, -128, -128, 0, 0, 4'b0000));
		// inner wheel ratio exactly zero
		send_item(make_cmd(ModeCommand, 40, 100, 0, 0, 4'b0000));
		// rounding truncates toward zero on a small negative product
		send_item(make_cmd(ModeCommand, -1, -1, 0, 0, 4'b0000));
		send_item(make_cmd(ModeCommand, 5, 50, 0, 0, FlagHalt));
		// obstacle while drives still at stop: accepted
		send_item(make_cmd(ModeCommand, 0, 100, 0, 0, FlagObst));
		send_item(make_cmd(ModeTick, -128, 127, 0, 0, 4'b0000));
		// both drives now above stop
		send_item(make_cmd(ModeCommand, 0, -50, 0, 0, FlagObst));
		send_item(make_cmd(ModeCommand, 10, 90, 0, 0, FlagObst | FlagIgnore));
		send_item(make_cmd(ModeCommand, -10, 80, 0, 0, FlagObst | FlagOverride));
		send_item(make_cmd(ModeCommand, 0, 80, 0, 0, 4'hF));
		send_item(make_cmd(ModeTick, 127, -128, -32768, 32767, 4'hF));
		send_item(make_cmd(ModeTick, 0, 0, -32768, 32767, 4'b0000));
		send_item(make_cmd(ModeTick, 0, 0, -32768, 32767, 4'b0000));
		// left at target, right above it
		send_item(make_cmd(ModeTick, 0, 0, tgt_l, 32767, 4'b0000));
		send_item(make_cmd(ModeSoftStop, -1, -1, 5, -5, 4'hF));
		send_item(make_cmd(ModeTick, 0, 0, 5, -5, 4'b0000));
		send_item(make_cmd(ModeHardStop, -1, -1, -1, -1, 4'hF));
		send_item(make_cmd(ModeTick, 0, 0, -1, -1, 4'b0000));
	endtask

	task automatic test_limits_and_stop_value();
		// drives start beyond the forward limit
		set_config(12'd700, 12'd640, 12'd384, 4'd0);
		send_item(make_cmd(ModeHardStop, 0, 0, 0, 0, 4'b0000));
		send_item(make_cmd(ModeTick, 0, 0, -100, -100, 4'b0000));
		send_item(make_cmd(ModeTick, 0, 0, 100, 100, 4'b0000));
		// new stop value leaves the drives alone
		set_config(12'd100, 12'd640, 12'd384, 4'd0);
		send_item(make_cmd(ModeTick, 0, 0, 0, 0, 4'b0000));
		send_item(make_cmd(ModeHardStop, 0, 0, 0, 0, 4'b0000));
		send_item(make_cmd(ModeTick, 0, 0, 100, 100, 4'b0000));
		send_item(make_cmd(ModeTick, 0, 0, -100, -100, 4'b0000));
		set_config(12'd0, 12'd0, 12'd0, 4'd0);
		send_item(make_cmd(ModeHardStop, 0, 0, 0, 0, 4'b0000));
		send_item(make_cmd(ModeTick, 0, 0, -1, 1, 4'b0000));
		send_item(make_cmd(ModeTick, 0, 0, 1, -1, 4'b0000));
		set_config(12'hFFF, 12'hFFF, 12'hFFF, 4'd15);
		send_item(make_cmd(ModeHardStop, 0, 0, 0, 0, 4'b0000));
		repeat (18) send_item(make_cmd(ModeTick, 0, 0, -1, 1, 4'b0000));
		set_config(StopValueReset, FwdLimitReset, BackLimitReset, HoldoffReset);
	endtask

	task automatic test_backpressure();
		int i;
		tx_gap_max = 0;
		long_hold_req = 1'b1;
		for (i = 0; i < 40; i++)
			send_item(random_item((i % 5 == 0) ? ModeCommand : ModeTick, -2));
		// sender waits for every result before going on
		wait_drained();
		tx_gap_max = 9;
	endtask

	task automatic test_random_traffic();
		int phase, phase_end, goal, drift, run_len, sel;
		logic [11:0] stop;
		goal = items_sent + RandomItems;
		phase = 0;
		while (items_sent < goal) begin
			case (phase % 4)
				0: begin
					stop = 12'($urandom_range(100, 3900));
					set_config(stop, stop + 12'($urandom_range(0, 20)),
						stop - 12'($urandom_range(0, 20)), 4'($urandom_range(0, 2)));
				end
				1: set_config(12'($urandom), 12'($urandom), 12'($urandom), 4'($urandom));
				2: begin
					set_config($urandom_range(0, 1) ? 12'hFFF : 12'h000,
						$urandom_range(0, 1) ? 12'hFFF : 12'h000,
						$urandom_range(0, 1) ? 12'hFFF : 12'h000,
						$urandom_range(0, 1) ? 4'hF : 4'h0);
				end
				default: set_config(StopValueReset, FwdLimitReset, BackLimitReset, HoldoffReset);
			endcase
			phase_end = items_sent + 150;
			while (items_sent < phase_end && items_sent < goal) begin
				tx_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 9;
				rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
				send_item(random_item(ModeCommand, 0));
				drift = int'($urandom_range(0, 6)) - 3;
				run_len = $urandom_range(4, 40);
				repeat (run_len) begin
					sel = $urandom_range(0, 19);
					if (sel == 0)
						send_item(random_item(ModeSoftStop, drift));
					else if (sel == 1)
						send_item(random_item(ModeHardStop, drift));
					else if (sel == 2)
						send_item(random_item(ModeCommand, drift));
					else
						send_item(random_item(ModeTick, drift));
				end
			end
			phase++;
		end
		tx_gap_max   = 9;
		rx_stall_max = 9;
	endtask

	initial begin
		reset_wheel_model();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_commands_and_ramp();
		test_limits_and_stop_value();
		test_backpressure();
		test_random_traffic();
		wait_drained();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> wheel_speed_ramp_controller_unit.f
src/wsrc_pkg.sv
src/wsrc_lane.sv
src/wsrc_out_fifo.sv
src/wheel_speed_ramp_controller_unit.sv
tb/tb_top.sv
